// ===== rtl/core/lorenz_euler_integrator_unit_assert.svh =====
// Assertion macros shared by the Lorenz integrator RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef LORENZ_EULER_INTEGRATOR_UNIT_ASSERT_SVH
`define LORENZ_EULER_INTEGRATOR_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define LEI_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lei: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LEI_CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lei: same-cycle check failed");

`endif

// ===== rtl/core/lei_pkg.sv =====
// Shared types, constants and helper functions of the Lorenz integrator.
// No dependencies; used by every module in rtl/core.
package lei_pkg;

  localparam int DATA_W        = 32;
  localparam int STEP_W        = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd6;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_C1   = 10'b0000000010,
    ST_C2   = 10'b0000000100,
    ST_C3   = 10'b0000001000,
    ST_C4   = 10'b0000010000,
    ST_C5   = 10'b0000100000,
    ST_C6   = 10'b0001000000,
    ST_C7   = 10'b0010000000,
    ST_C8   = 10'b0100000000,
    ST_C9   = 10'b1000000000
  } lei_state_t;

  typedef enum logic [2:0] {
    MA_X, MA_SIGMA, MA_BETA, MA_QOUT, MA_T1, MA_T3
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_Y, MB_Z, MB_T1, MB_T2, MB_DT
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    AA_Y, AA_RHO, AA_QOUT, AA_T3, AA_X, AA_Z
  } add_a_sel_t;

  typedef enum logic [2:0] {
    AB_X, AB_Z, AB_ZERO, AB_QOUT, AB_Y
  } add_b_sel_t;

  typedef enum logic [2:0] {
    AD_NONE, AD_T1, AD_T2, AD_T3, AD_X, AD_Y, AD_Z
  } add_dst_t;

  typedef struct packed {
    mul_a_sel_t ma;
    mul_b_sel_t mb;
    add_a_sel_t aa;
    add_b_sel_t ab;
    logic       sub;
    add_dst_t   dst;
    logic       done;
  } lei_ctrl_t;

  // Clamp an elaboration-time value to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat_const(input longint v);
    logic [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lei_qmul.sv =====
// Two-stage fixed-point multiplier: 32x32 product, then round-to-nearest
// at FRAC_BITS and saturation to 32 bits. Depends on lei_pkg.
module lei_qmul #(
  parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [lei_pkg::DATA_W-1:0] op_a,
  input  logic signed [lei_pkg::DATA_W-1:0] op_b,
  output logic signed [lei_pkg::DATA_W-1:0] q_out
);

  localparam int PW = 2 * lei_pkg::DATA_W;
  localparam logic signed [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] MAXV = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] MINV = -PW'(64'sd2147483648);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] rounded;
  logic signed [PW-1:0] shifted;
  logic signed [lei_pkg::DATA_W-1:0] q_nxt;
  logic signed [lei_pkg::DATA_W-1:0] q_r;

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
  end

  // The rounding bias cannot overflow: the product magnitude is at most 2^62.
  always_comb begin
    rounded = prod_r + RND;
    shifted = rounded >>> FRAC_BITS;
    if (shifted > MAXV) begin
      q_nxt = 32'sh7FFF_FFFF;
    end else if (shifted < MINV) begin
      q_nxt = 32'sh8000_0000;
    end else begin
      q_nxt = shifted[lei_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_out = q_r;

endmodule

// ===== rtl/core/lei_seq.sv =====
// Sequencer of one Euler step: runs through states C1 to C9 and issues
// operand selects for the shared multiplier and adder. Depends on lei_pkg.
module lei_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               idle,
  output lei_pkg::lei_ctrl_t ctrl
);

  lei_pkg::lei_state_t state_r;
  lei_pkg::lei_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lei_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lei_pkg::ST_IDLE: if (start) state_nxt = lei_pkg::ST_C1;
      lei_pkg::ST_C1:   state_nxt = lei_pkg::ST_C2;
      lei_pkg::ST_C2:   state_nxt = lei_pkg::ST_C3;
      lei_pkg::ST_C3:   state_nxt = lei_pkg::ST_C4;
      lei_pkg::ST_C4:   state_nxt = lei_pkg::ST_C5;
      lei_pkg::ST_C5:   state_nxt = lei_pkg::ST_C6;
      lei_pkg::ST_C6:   state_nxt = lei_pkg::ST_C7;
      lei_pkg::ST_C7:   state_nxt = lei_pkg::ST_C8;
      lei_pkg::ST_C8:   state_nxt = lei_pkg::ST_C9;
      lei_pkg::ST_C9:   state_nxt = lei_pkg::ST_IDLE;
      default:          state_nxt = lei_pkg::ST_IDLE;
    endcase
  end

  // Products are registered in prod_r and q_r of lei_qmul; each is consumed
  // (as QOUT) by a later state: C1's in C3, and so on up to C7's in C9.
  always_comb begin
    ctrl.ma   = lei_pkg::MA_X;
    ctrl.mb   = lei_pkg::MB_Y;
    ctrl.aa   = lei_pkg::AA_Y;
    ctrl.ab   = lei_pkg::AB_X;
    ctrl.sub  = 1'b0;
    ctrl.dst  = lei_pkg::AD_NONE;
    ctrl.done = 1'b0;
    unique case (state_r)
      lei_pkg::ST_IDLE: begin
      end
      lei_pkg::ST_C1: begin
        ctrl.ma  = lei_pkg::MA_X;    ctrl.mb  = lei_pkg::MB_Y;
        ctrl.aa  = lei_pkg::AA_Y;    ctrl.ab  = lei_pkg::AB_X;
        ctrl.sub = 1'b1;             ctrl.dst = lei_pkg::AD_T1;
      end
      lei_pkg::ST_C2: begin
        ctrl.ma  = lei_pkg::MA_BETA; ctrl.mb  = lei_pkg::MB_Z;
        ctrl.aa  = lei_pkg::AA_RHO;  ctrl.ab  = lei_pkg::AB_Z;
        ctrl.sub = 1'b1;             ctrl.dst = lei_pkg::AD_T2;
      end
      lei_pkg::ST_C3: begin
        ctrl.ma  = lei_pkg::MA_SIGMA; ctrl.mb = lei_pkg::MB_T1;
        ctrl.aa  = lei_pkg::AA_QOUT;  ctrl.ab = lei_pkg::AB_ZERO;
        ctrl.dst = lei_pkg::AD_T3;
      end
      lei_pkg::ST_C4: begin
        ctrl.ma  = lei_pkg::MA_X;    ctrl.mb  = lei_pkg::MB_T2;
        ctrl.aa  = lei_pkg::AA_T3;   ctrl.ab  = lei_pkg::AB_QOUT;
        ctrl.sub = 1'b1;             ctrl.dst = lei_pkg::AD_T3;
      end
      lei_pkg::ST_C5: begin
        ctrl.ma  = lei_pkg::MA_QOUT; ctrl.mb  = lei_pkg::MB_DT;
      end
      lei_pkg::ST_C6: begin
        ctrl.ma  = lei_pkg::MA_T3;   ctrl.mb  = lei_pkg::MB_DT;
        ctrl.aa  = lei_pkg::AA_QOUT; ctrl.ab  = lei_pkg::AB_Y;
        ctrl.sub = 1'b1;             ctrl.dst = lei_pkg::AD_T1;
      end
      lei_pkg::ST_C7: begin
        ctrl.ma  = lei_pkg::MA_T1;   ctrl.mb  = lei_pkg::MB_DT;
        ctrl.aa  = lei_pkg::AA_X;    ctrl.ab  = lei_pkg::AB_QOUT;
        ctrl.dst = lei_pkg::AD_X;
      end
      lei_pkg::ST_C8: begin
        ctrl.aa  = lei_pkg::AA_Z;    ctrl.ab  = lei_pkg::AB_QOUT;
        ctrl.dst = lei_pkg::AD_Z;
      end
      lei_pkg::ST_C9: begin
        ctrl.aa   = lei_pkg::AA_Y;   ctrl.ab  = lei_pkg::AB_QOUT;
        ctrl.dst  = lei_pkg::AD_Y;
        ctrl.done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign idle = (state_r == lei_pkg::ST_IDLE);

endmodule

// ===== rtl/core/lorenz_euler_integrator_unit.sv =====
// Lorenz system forward Euler integrator, signed fixed point with saturation.
// Depends on lei_pkg, lei_seq, lei_qmul and the assertion macro header.
//
// Usage:
//   in_*  : one transaction per command; in_tdata[0] is restart (1 reloads
//           the start point, 0 advances one Euler step).
//   out_* : one transaction per command carrying the new point, x in
//           out_tdata[31:0], y in [63:32], z in [95:64].
//   cfg_* : register writes (sigma, rho, beta, step, start x/y/z by index
//           0..6, larger indexes are ignored); always ready, write only
//           while no command is in flight.
// Timing: a restart result is valid the cycle after its transaction; a step
// result is loaded into the output register in state C9. A step runs through
// states C1 to C9 of the sequencer, set by seven dependent products through
// one two-stage multiplier and one saturating adder; no new command is taken
// until the step is finished.
// Reset loads the default coefficients and the start point 0.01, 0, 0.
// The output register holds a result until taken; in_tready stays low while
// a step is in progress or while a held result is not being taken.
module lorenz_euler_integrator_unit #(
  parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // restart at bit 0, bits 7:1 zero
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  output logic [3*lei_pkg::DATA_W-1:0]    out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lei_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lei_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW = lei_pkg::DATA_W;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic [DW-1:0] SIGMA_RST = lei_pkg::sat_const(10 * ONE_Q);
  localparam logic [DW-1:0] RHO_RST   = lei_pkg::sat_const(28 * ONE_Q);
  localparam logic [DW-1:0] BETA_RST  = lei_pkg::sat_const((8 * ONE_Q + 1) / 3);
  localparam logic [DW-1:0] HUND_RST  = lei_pkg::sat_const((ONE_Q + 50) / 100);

  logic signed [DW-1:0]           sigma_r, rho_r, beta_r;
  logic [lei_pkg::STEP_W-1:0]     step_r;
  logic signed [DW-1:0]           start_x_r, start_y_r, start_z_r;
  logic signed [DW-1:0]           x_r, y_r, z_r;
  logic signed [DW-1:0]           x_nxt, y_nxt, z_nxt;
  logic signed [DW-1:0]           t1_r, t2_r, t3_r;
  logic [3*DW-1:0]                out_data_r;
  logic                           out_valid_r;

  logic                           seq_idle;
  lei_pkg::lei_ctrl_t             ctrl;
  logic                           in_acc;
  logic                           restart_acc;
  logic                           step_acc;
  logic signed [DW-1:0]           mul_a, mul_b, q_out;
  logic signed [DW-1:0]           add_a, add_b;
  logic signed [DW:0]             add_sum;
  logic signed [DW-1:0]           add_res;

  assign cfg_ready   = 1'b1;
  assign in_tready   = seq_idle && (!out_valid_r || out_tready);
  assign in_acc      = in_tvalid && in_tready;
  assign restart_acc = in_acc && in_tdata[0];
  assign step_acc    = in_acc && !in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r   <= SIGMA_RST;
      rho_r     <= RHO_RST;
      beta_r    <= BETA_RST;
      step_r    <= HUND_RST[lei_pkg::STEP_W-1:0];
      start_x_r <= HUND_RST;
      start_y_r <= '0;
      start_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lei_pkg::REG_SIGMA:   sigma_r   <= cfg_data;
        lei_pkg::REG_RHO:     rho_r     <= cfg_data;
        lei_pkg::REG_BETA:    beta_r    <= cfg_data;
        lei_pkg::REG_STEP:    step_r    <= cfg_data[lei_pkg::STEP_W-1:0];
        lei_pkg::REG_START_X: start_x_r <= cfg_data;
        lei_pkg::REG_START_Y: start_y_r <= cfg_data;
        lei_pkg::REG_START_Z: start_z_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lei_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_acc),
    .idle  (seq_idle),
    .ctrl  (ctrl)
  );

  always_comb begin
    case (ctrl.ma)
      lei_pkg::MA_X:     mul_a = x_r;
      lei_pkg::MA_SIGMA: mul_a = sigma_r;
      lei_pkg::MA_BETA:  mul_a = beta_r;
      lei_pkg::MA_QOUT:  mul_a = q_out;
      lei_pkg::MA_T1:    mul_a = t1_r;
      lei_pkg::MA_T3:    mul_a = t3_r;
      default:           mul_a = x_r;
    endcase
    case (ctrl.mb)
      lei_pkg::MB_Y:  mul_b = y_r;
      lei_pkg::MB_Z:  mul_b = z_r;
      lei_pkg::MB_T1: mul_b = t1_r;
      lei_pkg::MB_T2: mul_b = t2_r;
      lei_pkg::MB_DT: mul_b = {1'b0, step_r};
      default:        mul_b = y_r;
    endcase
  end

  lei_qmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_qmul (
    .clk   (clk),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .q_out (q_out)
  );

  // Shared saturating adder/subtractor.
  always_comb begin
    case (ctrl.aa)
      lei_pkg::AA_Y:    add_a = y_r;
      lei_pkg::AA_RHO:  add_a = rho_r;
      lei_pkg::AA_QOUT: add_a = q_out;
      lei_pkg::AA_T3:   add_a = t3_r;
      lei_pkg::AA_X:    add_a = x_r;
      lei_pkg::AA_Z:    add_a = z_r;
      default:          add_a = y_r;
    endcase
    case (ctrl.ab)
      lei_pkg::AB_X:    add_b = x_r;
      lei_pkg::AB_Z:    add_b = z_r;
      lei_pkg::AB_ZERO: add_b = '0;
      lei_pkg::AB_QOUT: add_b = q_out;
      lei_pkg::AB_Y:    add_b = y_r;
      default:          add_b = '0;
    endcase
    if (ctrl.sub) begin
      add_sum = {add_a[DW-1], add_a} - {add_b[DW-1], add_b};
    end else begin
      add_sum = {add_a[DW-1], add_a} + {add_b[DW-1], add_b};
    end
    if (add_sum[DW] != add_sum[DW-1]) begin
      add_res = add_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      add_res = add_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.dst)
      lei_pkg::AD_T1: t1_r <= add_res;
      lei_pkg::AD_T2: t2_r <= add_res;
      lei_pkg::AD_T3: t3_r <= add_res;
      default: begin
      end
    endcase
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (restart_acc) begin
      x_nxt = start_x_r;
      y_nxt = start_y_r;
      z_nxt = start_z_r;
    end else begin
      case (ctrl.dst)
        lei_pkg::AD_X: x_nxt = add_res;
        lei_pkg::AD_Y: y_nxt = add_res;
        lei_pkg::AD_Z: z_nxt = add_res;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= HUND_RST;
      y_r <= '0;
      z_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // The slot is free or being freed whenever a transaction is taken, so a
  // finished step never finds the output register occupied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (restart_acc || ctrl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (restart_acc || ctrl.done) begin
      out_data_r <= {z_nxt, y_nxt, x_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "lorenz_euler_integrator_unit_assert.svh"

  `LEI_CHECK_NEXT(a_step_busy, step_acc, !in_tready)
  `LEI_CHECK_NEXT(a_restart_out, restart_acc,
                  out_tvalid && (out_tdata[DW-1:0] == $past(start_x_r)))
  `LEI_CHECK_NEXT(a_done_out, ctrl.done, out_tvalid && seq_idle)

endmodule

// ===== dv/tb_lorenz_euler_integrator_unit.sv =====
// Self-checking testbench for the Lorenz Euler integrator: drives restart and step
// commands, rewrites the coefficients between phases and checks every output point.
// Depends on lei_pkg and lorenz_euler_integrator_unit.
module tb_lorenz_euler_integrator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FX_FRAC = lei_pkg::FRAC_BITS_DEF;
  localparam int FX_ONE = 1 << FX_FRAC;
  localparam longint HUNDREDTH = (longint'(FX_ONE) + 50) / 100;
  localparam logic [lei_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [lei_pkg::DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [lei_pkg::DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;
  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_CMDS = 850;
  localparam int TAIL_CMDS = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // restart at bit 0, bits 7:1 zero
  logic [7:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // point_x [31:0], point_y [63:32], point_z [95:64]
  logic [3*lei_pkg::DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lei_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lei_pkg::DATA_W-1:0] cfg_data = '0;

  lorenz_euler_integrator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // Predicted block state: coefficients and the current point.
  longint coef [0:6];
  longint px, py, pz;

  bit pending_cmds [$];
  logic [3*lei_pkg::DATA_W-1:0] expected_points [$];

  bit tail_no_idle = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int points_checked = 0;
  int restarts_sent = 0;
  int steps_sent = 0;
  int cmds_queued = 0;
  int settings_loaded = 0;

  function automatic longint clamp32(input longint v);
    if (v > LIM_HI) return LIM_HI;
    if (v < LIM_LO) return LIM_LO;
    return v;
  endfunction

  // Round to nearest with ties toward plus infinity, then saturate.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) << (FX_FRAC - 1));
    return clamp32(p >>> FX_FRAC);
  endfunction

  function automatic void reset_model();
    coef[lei_pkg::REG_SIGMA] = clamp32(10 * longint'(FX_ONE));
    coef[lei_pkg::REG_RHO] = clamp32(28 * longint'(FX_ONE));
    coef[lei_pkg::REG_BETA] = clamp32((8 * longint'(FX_ONE) + 1) / 3);
    coef[lei_pkg::REG_STEP] = HUNDREDTH;
    coef[lei_pkg::REG_START_X] = HUNDREDTH;
    coef[lei_pkg::REG_START_Y] = 0;
    coef[lei_pkg::REG_START_Z] = 0;
    px = HUNDREDTH;
    py = 0;
    pz = 0;
  endfunction

  function automatic void apply_reg(input logic [lei_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lei_pkg::DATA_W-1:0] val);
    if (idx == lei_pkg::REG_STEP) begin
      coef[idx] = longint'({1'b0, val[lei_pkg::STEP_W-1:0]});
    end else if (idx != REG_SPARE) begin
      coef[idx] = longint'($signed(val));
    end
  endfunction

  // One command: either reload the start point or take one Euler step from the old point.
  function automatic void advance_point(input bit restart);
    longint dx, dy, dz;
    if (restart) begin
      px = coef[lei_pkg::REG_START_X];
      py = coef[lei_pkg::REG_START_Y];
      pz = coef[lei_pkg::REG_START_Z];
    end else begin
      dx = fx_mul(fx_mul(coef[lei_pkg::REG_SIGMA], clamp32(py - px)),
                  coef[lei_pkg::REG_STEP]);
      dy = fx_mul(clamp32(fx_mul(px, clamp32(coef[lei_pkg::REG_RHO] - pz)) - py),
                  coef[lei_pkg::REG_STEP]);
      dz = fx_mul(clamp32(fx_mul(px, py) - fx_mul(coef[lei_pkg::REG_BETA], pz)),
                  coef[lei_pkg::REG_STEP]);
      px = clamp32(px + dx);
      py = clamp32(py + dy);
      pz = clamp32(pz + dz);
    end
    expected_points.push_back({pz[31:0], py[31:0], px[31:0]});
  endfunction

  // Command driver: holds a transaction until it is taken, idles in random bursts.
  always @(posedge clk) begin : drive_cmds
    bit taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        advance_point(in_tdata[0]);
        if (in_tdata[0]) restarts_sent++;
        else steps_sent++;
      end
      if (in_tvalid && !taken) begin
        // Hold the offered command.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        if (!tail_no_idle && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else begin
          in_tdata <= {7'b0, pending_cmds.pop_front()};
          in_tvalid <= 1'b1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Point monitor: checks each output transaction against the oldest prediction.
  always @(posedge clk) begin : check_points
    logic [3*lei_pkg::DATA_W-1:0] want;
    string field_name [3];
    field_name = '{"point_x", "point_y", "point_z"};
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point, expected none, got %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (out_tdata[32*f +: 32] !== want[32*f +: 32]) begin
              $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name[f],
                       $signed(want[32*f +: 32]), $signed(out_tdata[32*f +: 32]));
              mismatch_count++;
            end
          end
        end
        points_checked++;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!tail_no_idle && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Must be entered at a rising edge; leaves cfg_valid high for the caller to lower.
  task automatic write_reg(input logic [lei_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lei_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic load_coeffs(input logic [lei_pkg::DATA_W-1:0] sigma,
                             input logic [lei_pkg::DATA_W-1:0] rho,
                             input logic [lei_pkg::DATA_W-1:0] beta,
                             input logic [lei_pkg::DATA_W-1:0] dt,
                             input logic [lei_pkg::DATA_W-1:0] sx,
                             input logic [lei_pkg::DATA_W-1:0] sy,
                             input logic [lei_pkg::DATA_W-1:0] sz, input bit poke_spare);
    @(posedge clk);
    if (poke_spare) write_reg(REG_SPARE, $urandom());
    write_reg(lei_pkg::REG_SIGMA, sigma);
    write_reg(lei_pkg::REG_RHO, rho);
    write_reg(lei_pkg::REG_BETA, beta);
    write_reg(lei_pkg::REG_STEP, dt);
    write_reg(lei_pkg::REG_START_X, sx);
    write_reg(lei_pkg::REG_START_Y, sy);
    write_reg(lei_pkg::REG_START_Z, sz);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Queue a run that starts with a restart and then mostly steps.
  task automatic queue_cmds(input int n, input int restart_odds);
    pending_cmds.push_back(1'b1);
    for (int k = 1; k < n; k++) pending_cmds.push_back($urandom_range(1, restart_odds) == 1);
    cmds_queued += n;
  endtask

  task automatic queue_list(input bit cmds [$]);
    foreach (cmds[k]) pending_cmds.push_back(cmds[k]);
    cmds_queued += cmds.size();
  endtask

  // The sender stays quiet until every predicted point has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_points.size() != 0);
  endtask

  task automatic load_random_coeffs();
    if ($urandom_range(0, 6) == 0) begin
      // Full-range coefficients, mostly saturating trajectories.
      load_coeffs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom_range(0, 1));
    end else begin
      load_coeffs(FX_ONE * 8 + $urandom_range(0, FX_ONE * 4),
                  FX_ONE * 20 + $urandom_range(0, FX_ONE * 10),
                  FX_ONE * 2 + $urandom_range(0, FX_ONE),
                  $urandom_range(FX_ONE / 1000, FX_ONE / 50),
                  $urandom_range(0, FX_ONE * 40) - FX_ONE * 20,
                  $urandom_range(0, FX_ONE * 40) - FX_ONE * 20,
                  $urandom_range(0, FX_ONE * 50), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Steps from the reset point with reset coefficients, then a restart and more steps.
    queue_list('{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    wait_drained();

    // Coefficients and start point at the extremes; the step write has bit 31 set.
    load_coeffs(Q_MAX, Q_MIN, Q_MAX, 32'hFFFF_FFFF, Q_MAX, Q_MIN, Q_MAX, 1'b1);
    queue_list('{1'b1, 1'b0, 1'b0, 1'b0});
    wait_drained();

    // Opposite extremes with a zero time step, so the point must not move.
    load_coeffs(Q_MIN, Q_MAX, Q_MIN, 32'h0, Q_MIN, Q_MAX, Q_MIN, 1'b1);
    queue_list('{1'b1, 1'b0, 1'b0});
    wait_drained();

    // Largest time step from the origin, which is a fixed point.
    load_coeffs(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_list('{1'b1, 1'b0, 1'b0});
    wait_drained();

    // Half-unit gains on odd values land products exactly on rounding ties.
    load_coeffs(FX_ONE / 2, 32'h0, -(FX_ONE / 2), FX_ONE, 32'd3, -32'sd3, 32'd5, 1'b0);
    queue_list('{1'b1, 1'b0, 1'b0, 1'b0});
    wait_drained();

    while (cmds_queued < TARGET_CMDS - TAIL_CMDS) begin
      load_random_coeffs();
      queue_cmds($urandom_range(30, 90), 25);
      wait_drained();
    end

    // Final stretch at full rate on both sides.
    tail_no_idle = 1'b1;
    load_random_coeffs();
    queue_cmds(TAIL_CMDS, 25);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d points from %0d restarts and %0d steps over %0d register settings.",
             points_checked, restarts_sent, steps_sent, settings_loaded + 1);
    $display("Settings covered reset values, saturating extremes, a zero step and rounding ties.");
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lei_pkg.sv
rtl/core/lei_qmul.sv
rtl/core/lei_seq.sv
rtl/core/lorenz_euler_integrator_unit.sv
dv/tb_lorenz_euler_integrator_unit.sv
